>>> src/cmcd_pkg.sv
// Shared types and constants for the clipped, masked circle drawer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cmcd_pkg;

    localparam int SIZE_DEF   = 256;
    localparam int PLANES_DEF = 2;

    // signed width of a plotted coordinate: center (0..255) plus/minus offset (0..255)
    localparam int CW = 10;
    localparam int XW = 9;
    localparam int DW = 13;

    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd1;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

    localparam logic [7:0] CLIP_LEFT_RST   = 8'd0;
    localparam logic [7:0] CLIP_RIGHT_RST  = 8'd255;
    localparam logic [7:0] CLIP_TOP_RST    = 8'd0;
    localparam logic [7:0] CLIP_BOTTOM_RST = 8'd255;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_POINT,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] top;
        logic [7:0] bottom;
    } clip_t;

    typedef struct packed {
        logic clr_en;    // write zero at the sweep address
        logic load;      // latch the input item, start the walk for a draw
        logic rd_en;     // read the pixel of the current point
        logic wr_en;     // write back the modified pixel
        logic next_pt;   // advance to the next symmetric point
        logic step;      // advance the walk by one step
        logic out_load;  // load the result register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic req_read;  // action of the item offered at the input
        logic walk_on;   // x <= y
        logic keep;      // current point lies on the frame and in the clip window
        logic last_pt;
        logic out_space;
    } sts_t;

endpackage

>>> src/clipped_masked_circle_drawer.sv
// Top level of the clipped, masked circle drawer: clip window registers and
// the controller and datapath. Depends on cmcd_pkg, cmcd_ctrl, cmcd_dp.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | in_valid / in_ready  | action plane x_coord y_coord radius color mask
//  output   | out_valid / out_ready| read_value
//  config   | cfg_wr_en            | cfg_index cfg_data
//
// After reset the frame store is swept to zero, one pixel a cycle, across all
// PLANES*SIZE*SIZE pixels (131072 at the defaults); no item is taken meanwhile.
// A read passes through the READ and DONE states. A draw passes, per walk step,
// through CHECK and, for each of the eight points, POINT and also WRITE when
// the point is kept, then ends in DONE; the store's read-modify-write sets this.
// The next item is taken while a finished result still waits at the output.

module clipped_masked_circle_drawer #(
    parameter int SIZE   = cmcd_pkg::SIZE_DEF,
    parameter int PLANES = cmcd_pkg::PLANES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic       plane,
    input  logic [7:0] x_coord,
    input  logic [7:0] y_coord,
    input  logic [7:0] radius,
    input  logic [7:0] color,
    input  logic [7:0] mask,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_value,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cmcd_pkg::clip_t clip_reg;
    cmcd_pkg::cmd_t  cmd;
    cmcd_pkg::sts_t  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= cmcd_pkg::CLIP_LEFT_RST;
            clip_reg.right  <= cmcd_pkg::CLIP_RIGHT_RST;
            clip_reg.top    <= cmcd_pkg::CLIP_TOP_RST;
            clip_reg.bottom <= cmcd_pkg::CLIP_BOTTOM_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cmcd_pkg::REG_CLIP_LEFT:   clip_reg.left   <= cfg_data;
                cmcd_pkg::REG_CLIP_RIGHT:  clip_reg.right  <= cfg_data;
                cmcd_pkg::REG_CLIP_TOP:    clip_reg.top    <= cfg_data;
                cmcd_pkg::REG_CLIP_BOTTOM: clip_reg.bottom <= cfg_data;
                default:                   clip_reg        <= clip_reg;
            endcase
        end
    end

    cmcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmcd_dp #(
        .SIZE   (SIZE),
        .PLANES (PLANES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .clip       (clip_reg),
        .action     (action),
        .plane      (plane),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .radius     (radius),
        .color      (color),
        .mask       (mask),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value)
    );

endmodule

>>> src/cmcd_ctrl.sv
// Controller state machine of the circle drawer: sweeps the frame store after
// reset, then sequences reads, walk steps and per-point read-modify-write.
// Depends on cmcd_pkg.
`timescale 1ns / 1ps

module cmcd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cmcd_pkg::sts_t  sts,
    output cmcd_pkg::cmd_t  cmd
);

    cmcd_pkg::state_t state_reg;
    cmcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmcd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmcd_pkg::ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = cmcd_pkg::ST_IDLE;
                end
            end
            cmcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.req_read ? cmcd_pkg::ST_READ : cmcd_pkg::ST_CHECK;
                end
            end
            cmcd_pkg::ST_READ:
            begin
                state_next = cmcd_pkg::ST_DONE;
            end
            cmcd_pkg::ST_CHECK:
            begin
                state_next = sts.walk_on ? cmcd_pkg::ST_POINT : cmcd_pkg::ST_DONE;
            end
            cmcd_pkg::ST_POINT:
            begin
                if (sts.keep)
                begin
                    state_next = cmcd_pkg::ST_WRITE;
                end
                else if (sts.last_pt)
                begin
                    state_next = cmcd_pkg::ST_CHECK;
                end
            end
            cmcd_pkg::ST_WRITE:
            begin
                state_next = sts.last_pt ? cmcd_pkg::ST_CHECK : cmcd_pkg::ST_POINT;
            end
            cmcd_pkg::ST_DONE:
            begin
                if (sts.out_space)
                begin
                    state_next = cmcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            cmcd_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            cmcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cmcd_pkg::ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            cmcd_pkg::ST_CHECK:
            begin
            end
            cmcd_pkg::ST_POINT:
            begin
                cmd.rd_en   = 1'b1;
                cmd.next_pt = !sts.keep;
                cmd.step    = !sts.keep && sts.last_pt;
            end
            cmcd_pkg::ST_WRITE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.next_pt = 1'b1;
                cmd.step    = sts.last_pt;
            end
            cmcd_pkg::ST_DONE:
            begin
                cmd.out_load = sts.out_space;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> src/cmcd_dp.sv
// Datapath of the circle drawer: frame store memory, item latch, circle walk
// registers, point generation with frame and clip tests, result register.
// Depends on cmcd_pkg.
`timescale 1ns / 1ps

module cmcd_dp #(
    parameter int SIZE   = cmcd_pkg::SIZE_DEF,
    parameter int PLANES = cmcd_pkg::PLANES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cmcd_pkg::cmd_t  cmd,
    output cmcd_pkg::sts_t  sts,
    input  cmcd_pkg::clip_t clip,
    input  logic            action,
    input  logic            plane,
    input  logic [7:0]      x_coord,
    input  logic [7:0]      y_coord,
    input  logic [7:0]      radius,
    input  logic [7:0]      color,
    input  logic [7:0]      mask,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      read_value
);

    localparam int DEPTH = PLANES * SIZE * SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = cmcd_pkg::CW;
    localparam int XW    = cmcd_pkg::XW;
    localparam int DW    = cmcd_pkg::DW;

    logic [7:0] frame_mem [DEPTH];

    logic          act_reg;
    logic          plane_reg;
    logic [7:0]    cx_reg;
    logic [7:0]    cy_reg;
    logic [7:0]    color_reg;
    logic [7:0]    mask_reg;

    logic [XW-1:0] x_reg, x_next;
    logic [XW-1:0] y_reg, y_next;
    logic [DW-1:0] d_reg, d_next;
    logic [2:0]    pt_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    rd_data_reg;
    logic          ok_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    logic [XW-1:0] off_a, off_b;
    logic [CW-1:0] col, row;
    logic          in_frame, in_clip;
    logic [31:0]   addr_wide;
    logic [AW-1:0] pt_addr;
    logic [7:0]    wr_data;

    // item latch and walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            plane_reg <= plane;
            cx_reg    <= x_coord;
            cy_reg    <= y_coord;
            color_reg <= color;
            mask_reg  <= mask;
        end
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        d_next = d_reg;
        if (cmd.load && action == cmcd_pkg::ACT_DRAW)
        begin
            x_next = '0;
            y_next = XW'(radius);
            d_next = DW'(3) - (DW'(radius) << 1);
        end
        else if (cmd.step)
        begin
            x_next = x_reg + XW'(1);
            if (d_reg[DW-1])
            begin
                d_next = d_reg + (DW'(x_reg) << 2) + DW'(6);
            end
            else
            begin
                d_next = d_reg + ((DW'(x_reg) - DW'($signed(y_reg))) << 2) + DW'(10);
                y_next = y_reg - XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            d_reg         <= '0;
            pt_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
            if (cmd.load)
            begin
                pt_reg <= '0;
            end
            else if (cmd.next_pt)
            begin
                pt_reg <= pt_reg + 3'd1;
            end
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // point pt_reg: bit 2 swaps x and y, bit 1 negates the column, bit 0 the row
    always_comb
    begin
        if (act_reg == cmcd_pkg::ACT_READ)
        begin
            off_a = '0;
            off_b = '0;
        end
        else if (pt_reg[2])
        begin
            off_a = y_reg;
            off_b = x_reg;
        end
        else
        begin
            off_a = x_reg;
            off_b = y_reg;
        end
        col = pt_reg[1] ? CW'(cx_reg) - CW'(off_a) : CW'(cx_reg) + CW'(off_a);
        row = pt_reg[0] ? CW'(cy_reg) - CW'(off_b) : CW'(cy_reg) + CW'(off_b);
        if (act_reg == cmcd_pkg::ACT_READ)
        begin
            col = CW'(cx_reg);
            row = CW'(cy_reg);
        end
    end

    assign in_frame = (32'(plane_reg) < 32'(PLANES)) && !col[CW-1] && !row[CW-1]
                   && (32'(col[CW-2:0]) < 32'(SIZE)) && (32'(row[CW-2:0]) < 32'(SIZE));
    assign in_clip  = (col[CW-2:0] >= {1'b0, clip.left})  && (col[CW-2:0] <= {1'b0, clip.right})
                   && (row[CW-2:0] >= {1'b0, clip.top})   && (row[CW-2:0] <= {1'b0, clip.bottom});

    assign addr_wide = (32'(plane_reg) * 32'(SIZE) + 32'(row[CW-2:0])) * 32'(SIZE)
                     + 32'(col[CW-2:0]);
    assign pt_addr   = addr_wide[AW-1:0];
    assign wr_data   = (rd_data_reg & ~mask_reg) | (color_reg & mask_reg);

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            frame_mem[clr_reg] <= 8'd0;
        end
        else if (cmd.wr_en)
        begin
            frame_mem[addr_reg] <= wr_data;
        end
        if (cmd.rd_en && in_frame)
        begin
            rd_data_reg <= frame_mem[pt_addr];
        end
        if (cmd.rd_en)
        begin
            addr_reg <= pt_addr;
            ok_reg   <= in_frame;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= (act_reg == cmcd_pkg::ACT_READ && ok_reg) ? rd_data_reg : 8'd0;
        end
    end

    assign sts.clr_done  = (32'(clr_reg) == 32'(DEPTH - 1));
    assign sts.req_read  = (action == cmcd_pkg::ACT_READ);
    assign sts.walk_on   = $signed({1'b0, x_reg}) <= $signed({y_reg[XW-1], y_reg});
    assign sts.keep      = in_frame && in_clip;
    assign sts.last_pt   = (pt_reg == 3'd7);
    assign sts.out_space = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg;

endmodule
